[hdl/brf_pkg.sv]
// shared types and constants for the byte ring fifo with items
// no dependencies; imported by every module of the block
`default_nettype none

package brf_pkg;

  localparam int OP_W      = 3;
  localparam int BYTE_W    = 8;
  localparam int ITEM_W    = 64;
  localparam int CNT_W     = 10;
  localparam int LEN_W     = 11;
  localparam int SZ_W      = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 11;

  // reset value of the ring length register
  localparam int BUFFER_LEN_RESET = 1024;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ITEM_SIZE  = 2'd1;

  typedef enum logic [OP_W-1:0] {
    OP_PUT_BYTE   = 3'd0,
    OP_FORCE_BYTE = 3'd1,
    OP_GET_BYTE   = 3'd2,
    OP_PUT_ITEM   = 3'd3,
    OP_FORCE_ITEM = 3'd4,
    OP_GET_ITEM   = 3'd5,
    OP_CLEAR      = 3'd6,
    OP_NOP        = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SKIP,
    ST_WRITE,
    ST_READ,
    ST_CALC,
    ST_CHECK,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

[hdl/byte_ring_fifo_with_items_top.sv]
// byte ring fifo with fixed-size items: control sequencer, indices and counts
// depends on brf_pkg and brf_ram
`default_nettype none

// Usage
//   in channel (in_valid/in_ready) carries one operation word: op, byte_in,
//   item_in. out channel (out_valid/out_ready) returns exactly one result word
//   per operation: ok, byte_out, item_out, valid_bytes, free_bytes, valid_items.
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes buffer_len
//   (index 0, also zeroes both indices) or item_size (index 1); write it only
//   while no operation is in flight. cfg_ready is always high.
// Sequence
//   the bytes live in one byte-wide memory with one write and one read port,
//   so item work moves one byte per cycle. states from the accepting cycle
//   through the cycle that loads the result:
//     byte ops, clear, refused item ops: idle, calc, done
//     put item / get item: idle, one write or read per item byte, calc, done
//     forced item put that must skip: idle, one skip per item byte, calc,
//       check, then one write per item byte, calc, done (check to done if refused)
//   a new word is taken in the cycle after the previous result is loaded, so
//   no word is taken before the block is through with the one before.
// Reset
//   synchronous rst empties the ring (indices zero), sets buffer_len to 1024
//   (clamped to DEPTH) and item_size to 1; memory contents are not cleared.
// Stall
//   the result sits in an output register; while it waits, the next word is
//   accepted and processed, and its result is held until the register frees.
module byte_ring_fifo_with_items_top #(
  parameter int DEPTH          = 1024,
  parameter int MAX_ITEM_BYTES = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [brf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [brf_pkg::CFG_W-1:0]     cfg_data,
  // operation words in
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [brf_pkg::OP_W-1:0]      op,
  input  wire logic [brf_pkg::BYTE_W-1:0]    byte_in,
  input  wire logic [brf_pkg::ITEM_W-1:0]    item_in,
  // result words out
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               ok,
  output logic      [brf_pkg::BYTE_W-1:0]    byte_out,
  output logic      [brf_pkg::ITEM_W-1:0]    item_out,
  output logic      [brf_pkg::CNT_W-1:0]     valid_bytes,
  output logic      [brf_pkg::CNT_W-1:0]     free_bytes,
  output logic      [brf_pkg::CNT_W-1:0]     valid_items
);
  import brf_pkg::*;

  // index, lane counter and compare widths, and the reset ring length
  localparam int IW  = $clog2(DEPTH);
  localparam int LNW = (MAX_ITEM_BYTES > 1) ? $clog2(MAX_ITEM_BYTES) : 1;
  localparam int CW  = (IW > SZ_W) ? IW : SZ_W;
  localparam int RESET_LEN = (DEPTH < BUFFER_LEN_RESET) ? DEPTH : BUFFER_LEN_RESET;

  // valid_items = vcnt / item_size as a multiply by a rounded-up reciprocal;
  // with 3 extra fraction bits the quotient is exact for every count below DEPTH
  localparam int K  = IW + 3;
  localparam int MW = K + 1;
  localparam logic [MW-1:0] RECIP [8] = '{
    MW'(((1 << K) + 0) / 1),
    MW'(((1 << K) + 1) / 2),
    MW'(((1 << K) + 2) / 3),
    MW'(((1 << K) + 3) / 4),
    MW'(((1 << K) + 4) / 5),
    MW'(((1 << K) + 5) / 6),
    MW'(((1 << K) + 6) / 7),
    MW'(((1 << K) + 7) / 8)
  };

  function automatic logic [IW-1:0] ring_inc(input logic [IW-1:0] x,
                                             input logic [IW-1:0] last);
    logic [IW-1:0] y;
    y = (x == last) ? '0 : x + IW'(1);
    return y;
  endfunction

  // sequencer
  state_t state, state_next;

  // ring state
  logic [IW-1:0]   w_idx;
  logic [IW-1:0]   r_idx;
  logic [IW-1:0]   nm1;        // ring length minus one
  logic [IW-1:0]   vcnt;       // stored bytes, updated after every operation
  logic [IW-1:0]   fcnt;       // free bytes
  logic [SZ_W-1:0] sz;         // clamped item size

  // per-operation working registers
  op_t             op_q;
  logic            ok_q;
  logic [ITEM_W-1:0] item_q;
  logic [LNW-1:0]  lane;
  logic [LNW-1:0]  rd_lane;
  logic            rd_pend;
  logic            recheck;

  // memory port
  logic              ram_we;
  logic [BYTE_W-1:0] ram_wdata;
  logic [BYTE_W-1:0] ram_rdata;

  // combinational helpers
  op_t             op_in;
  logic            accept;
  logic            load_out;
  logic            is_full;
  logic            is_empty;
  logic            room_item;
  logic            have_item;
  logic            lane_last;
  logic [IW-1:0]   valid_calc;
  logic [IW-1:0]   cfg_nm1;
  logic [SZ_W-1:0] cfg_sz;
  logic [LEN_W-1:0] cfg_len;
  logic [IW+MW-1:0] prod;

  assign op_in     = op_t'(op);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign is_full   = (fcnt == '0);
  assign is_empty  = (vcnt == '0);
  assign room_item = (CW'(sz) <= CW'(fcnt));
  assign have_item = (CW'(vcnt) >= CW'(sz));
  assign lane_last = (SZ_W'(lane) == (sz - SZ_W'(1)));

  // occupancy from the indices
  assign valid_calc = (w_idx >= r_idx) ? (w_idx - r_idx)
                                       : (nm1 - r_idx + w_idx + IW'(1));

  assign prod = (IW+MW)'(vcnt) * (IW+MW)'(RECIP[3'(sz - SZ_W'(1))]);

  // configuration clamps
  assign cfg_len = cfg_data[LEN_W-1:0];

  always_comb begin
    priority if (cfg_len < LEN_W'(2)) begin
      cfg_nm1 = IW'(1);
    end else if (32'(cfg_len) > DEPTH) begin
      cfg_nm1 = IW'(DEPTH - 1);
    end else begin
      cfg_nm1 = IW'(cfg_len - LEN_W'(1));
    end
  end

  always_comb begin
    priority if (cfg_data[SZ_W-1:0] == '0) begin
      cfg_sz = SZ_W'(1);
    end else if (32'(cfg_data[SZ_W-1:0]) > MAX_ITEM_BYTES) begin
      cfg_sz = SZ_W'(MAX_ITEM_BYTES);
    end else begin
      cfg_sz = cfg_data[SZ_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (op_in)
            OP_PUT_ITEM:   state_next = room_item ? ST_WRITE : ST_CALC;
            OP_FORCE_ITEM: state_next = room_item ? ST_WRITE : ST_SKIP;
            OP_GET_ITEM:   state_next = have_item ? ST_READ  : ST_CALC;
            default:       state_next = ST_CALC;
          endcase
        end
      end
      ST_SKIP:  state_next = lane_last ? ST_CALC : ST_SKIP;
      ST_WRITE: state_next = lane_last ? ST_CALC : ST_WRITE;
      ST_READ:  state_next = lane_last ? ST_CALC : ST_READ;
      ST_CALC:  state_next = recheck ? ST_CHECK : ST_DONE;
      ST_CHECK: state_next = room_item ? ST_WRITE : ST_DONE;
      ST_DONE:  state_next = (!out_valid || out_ready) ? ST_IDLE : ST_DONE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_wdata = byte_in;
    load_out  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ram_we = ((op_in == OP_PUT_BYTE) && !is_full) || (op_in == OP_FORCE_BYTE);
        end
      end
      ST_WRITE: begin
        ram_we    = 1'b1;
        ram_wdata = item_q[BYTE_W*lane +: BYTE_W];
      end
      ST_DONE:  load_out = !out_valid || out_ready;
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      w_idx     <= '0;
      r_idx     <= '0;
      nm1       <= IW'(RESET_LEN - 1);
      vcnt      <= '0;
      fcnt      <= IW'(RESET_LEN - 1);
      sz        <= SZ_W'(1);
      lane      <= '0;
      rd_pend   <= 1'b0;
      recheck   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;

      // a byte read is issued by a successful get byte and by every read step
      rd_pend <= ((state == ST_IDLE) && accept && (op_in == OP_GET_BYTE) && !is_empty)
                 || (state == ST_READ);

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            lane    <= '0;
            recheck <= (op_in == OP_FORCE_ITEM) && !room_item;
            unique case (op_in)
              OP_PUT_BYTE: begin
                if (!is_full) begin
                  w_idx <= ring_inc(w_idx, nm1);
                end
              end
              OP_FORCE_BYTE: begin
                // full: drop the oldest byte first
                if (is_full) begin
                  r_idx <= ring_inc(r_idx, nm1);
                end
                w_idx <= ring_inc(w_idx, nm1);
              end
              OP_GET_BYTE: begin
                if (!is_empty) begin
                  r_idx <= ring_inc(r_idx, nm1);
                end
              end
              OP_CLEAR: begin
                w_idx <= '0;
                r_idx <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SKIP: begin
          r_idx <= ring_inc(r_idx, nm1);
          lane  <= lane + LNW'(1);
        end
        ST_WRITE: begin
          w_idx <= ring_inc(w_idx, nm1);
          lane  <= lane + LNW'(1);
        end
        ST_READ: begin
          r_idx   <= ring_inc(r_idx, nm1);
          lane    <= lane + LNW'(1);
        end
        ST_CALC: begin
          vcnt <= valid_calc;
          fcnt <= nm1 - valid_calc;
          lane <= '0;
        end
        ST_CHECK: recheck <= 1'b0;
        ST_DONE: begin
        end
        default: begin
        end
      endcase

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      // configuration writes must arrive only while idle; the block does not enforce this
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_BUFFER_LEN: begin
            nm1   <= cfg_nm1;
            w_idx <= '0;
            r_idx <= '0;
            vcnt  <= '0;
            fcnt  <= cfg_nm1;
          end
          CFG_ITEM_SIZE: sz <= cfg_sz;
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_lane <= lane;

    if (accept) begin
      op_q   <= op_in;
      item_q <= ((op_in == OP_PUT_ITEM) || (op_in == OP_FORCE_ITEM)) ? item_in : '0;
      unique case (op_in)
        OP_PUT_BYTE:   ok_q <= !is_full;
        OP_FORCE_BYTE: ok_q <= 1'b1;
        OP_GET_BYTE:   ok_q <= !is_empty;
        OP_PUT_ITEM:   ok_q <= room_item;
        OP_FORCE_ITEM: ok_q <= room_item;
        OP_GET_ITEM:   ok_q <= have_item;
        OP_CLEAR:      ok_q <= 1'b1;
        default:       ok_q <= 1'b0;
      endcase
    end

    // retry after skipping at the read side
    if (state == ST_CHECK) begin
      ok_q <= room_item;
    end

    // read data lands in the cycle after the read was issued
    if (rd_pend) begin
      item_q[BYTE_W*rd_lane +: BYTE_W] <= ram_rdata;
    end

    if (load_out) begin
      ok          <= ok_q;
      byte_out    <= (op_q == OP_GET_BYTE) ? item_q[BYTE_W-1:0] : '0;
      item_out    <= (op_q == OP_GET_ITEM) ? item_q : '0;
      valid_bytes <= CNT_W'(vcnt);
      free_bytes  <= CNT_W'(fcnt);
      valid_items <= CNT_W'(prod[K +: IW]);
    end
  end

  // byte store; read port always follows the read index
  brf_ram #(
    .DEPTH (DEPTH),
    .AW    (IW)
  ) u_brf_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (w_idx),
    .wdata (ram_wdata),
    .raddr (r_idx),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

[hdl/brf_ram.sv]
// byte-wide single-port-write, single-port-read store with registered read data
// depends on brf_pkg for the byte width
`default_nettype none

module brf_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [AW-1:0]             waddr,
  input  wire logic [brf_pkg::BYTE_W-1:0] wdata,
  input  wire logic [AW-1:0]             raddr,
  output logic      [brf_pkg::BYTE_W-1:0] rdata
);
  import brf_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hdl/brf_checker.sv]
// port-level checks for the byte ring fifo, bound to the top level
// depends on brf_pkg and byte_ring_fifo_with_items_top
`default_nettype none

module brf_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          cfg_valid,
  input wire logic                          cfg_ready,
  input wire logic [brf_pkg::CFG_IDX_W-1:0] cfg_index,
  input wire logic [brf_pkg::CFG_W-1:0]     cfg_data,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic [brf_pkg::OP_W-1:0]      op,
  input wire logic [brf_pkg::BYTE_W-1:0]    byte_in,
  input wire logic [brf_pkg::ITEM_W-1:0]    item_in,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic                          ok,
  input wire logic [brf_pkg::BYTE_W-1:0]    byte_out,
  input wire logic [brf_pkg::ITEM_W-1:0]    item_out,
  input wire logic [brf_pkg::CNT_W-1:0]     valid_bytes,
  input wire logic [brf_pkg::CNT_W-1:0]     free_bytes,
  input wire logic [brf_pkg::CNT_W-1:0]     valid_items
);
  import brf_pkg::*;

  // no result word survives reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word present after reset");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(ok) && $stable(byte_out)
      && $stable(item_out) && $stable(valid_bytes) && $stable(free_bytes)
      && $stable(valid_items))
    else $error("stalled result word changed");

  // every accepted operation leaves the block busy in the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("word accepted on back-to-back cycles");

  // read data only comes from a successful get
  a_data_needs_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((byte_out != '0) || (item_out != '0)) |-> ok)
    else $error("read data on a refused operation");

  // a word carries either byte data or item data, never both
  a_one_data_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && (byte_out != '0) |-> (item_out == '0))
    else $error("byte and item data in one result word");

endmodule

bind byte_ring_fifo_with_items_top brf_checker u_brf_checker (.*);

`default_nettype wire
